// File: design/sftr_pkg.sv
package sftr_pkg;

    localparam int GLYPH_COLS   = 5;
    localparam int GLYPH_ROWS   = 8;
    localparam int GLYPH_W      = GLYPH_COLS * GLYPH_ROWS;
    localparam int COORD_W      = 16;
    localparam int SCALE_W      = 4;
    localparam int CODE_W       = 8;
    localparam int ROW_IDX_W    = $clog2(GLYPH_ROWS);
    localparam int ADV_W        = SCALE_W + 3;

    localparam logic [CODE_W-1:0]    NEWLINE_CODE = 8'h0A;
    localparam logic [CODE_W-1:0]    GLYPH_FIRST  = 8'h20;
    localparam logic [CODE_W-1:0]    GLYPH_LAST   = 8'h7A;
    localparam logic [ROW_IDX_W-1:0] LAST_ROW     = ROW_IDX_W'(GLYPH_ROWS - 1);

    // column c of the glyph sits in bits [8*c+7 : 8*c], dot row r at bit r of that byte
    typedef logic [GLYPH_W-1:0] glyph_t;

    typedef struct packed {
        logic                      valid;
        logic                      last;
        logic [COORD_W-1:0]        x;
        logic [COORD_W-1:0]        y;
        logic [SCALE_W-1:0]        side;
    } dot_t;

    function automatic glyph_t font_glyph(input logic [CODE_W-1:0] code);
        glyph_t g;
        begin
            case (code)
                8'h21: g = 40'h00005F0000;
                8'h22: g = 40'h0007000700;
                8'h23: g = 40'h147F147F14;
                8'h24: g = 40'h122A7F2A24;
                8'h25: g = 40'h6264081323;
                8'h26: g = 40'h5022554936;
                8'h27: g = 40'h0000030500;
                8'h28: g = 40'h0041221C00;
                8'h29: g = 40'h001C224100;
                8'h2A: g = 40'h14083E0814;
                8'h2B: g = 40'h08083E0808;
                8'h2C: g = 40'h0000305000;
                8'h2D: g = 40'h0808080808;
                8'h2E: g = 40'h0000606000;
                8'h2F: g = 40'h0204081020;
                8'h30: g = 40'h3E4549513E;
                8'h31: g = 40'h00407F4200;
                8'h32: g = 40'h4649516142;
                8'h33: g = 40'h314B454121;
                8'h34: g = 40'h107F121418;
                8'h35: g = 40'h3945454527;
                8'h36: g = 40'h3049494A3C;
                8'h37: g = 40'h0305097101;
                8'h38: g = 40'h3649494936;
                8'h39: g = 40'h1E29494906;
                8'h3A: g = 40'h0000363600;
                8'h3B: g = 40'h0000365600;
                8'h3C: g = 40'h0041221408;
                8'h3D: g = 40'h1414141414;
                8'h3E: g = 40'h0814224100;
                8'h3F: g = 40'h0609510102;
                8'h40: g = 40'h3E41794932;
                8'h41: g = 40'h7E1111117E;
                8'h42: g = 40'h364949497F;
                8'h43: g = 40'h224141413E;
                8'h44: g = 40'h1C2241417F;
                8'h45: g = 40'h414949497F;
                8'h46: g = 40'h010909097F;
                8'h47: g = 40'h7A4949413E;
                8'h48: g = 40'h7F0808087F;
                8'h49: g = 40'h00417F4100;
                8'h4A: g = 40'h013F414020;
                8'h4B: g = 40'h412214087F;
                8'h4C: g = 40'h404040407F;
                8'h4D: g = 40'h7F020C027F;
                8'h4E: g = 40'h7F1008047F;
                8'h4F: g = 40'h3E4141413E;
                8'h50: g = 40'h060909097F;
                8'h51: g = 40'h5E2151413E;
                8'h52: g = 40'h462919097F;
                8'h53: g = 40'h3149494946;
                8'h54: g = 40'h01017F0101;
                8'h55: g = 40'h3F4040403F;
                8'h56: g = 40'h1F2040201F;
                8'h57: g = 40'h3F4038403F;
                8'h58: g = 40'h6314081463;
                8'h59: g = 40'h0708700807;
                8'h5A: g = 40'h4345495161;
                8'h5B: g = 40'h0041417F00;
                8'h5C: g = 40'h2010080402;
                8'h5D: g = 40'h007F414100;
                8'h5E: g = 40'h0402010204;
                8'h5F: g = 40'h4040404040;
                8'h60: g = 40'h0004020100;
                8'h61: g = 40'h7854545420;
                8'h62: g = 40'h384444487F;
                8'h63: g = 40'h2044444438;
                8'h64: g = 40'h7F48444438;
                8'h65: g = 40'h1854545438;
                8'h66: g = 40'h0201097E08;
                8'h67: g = 40'h3E5252520C;
                8'h68: g = 40'h780404087F;
                8'h69: g = 40'h00407D4400;
                8'h6A: g = 40'h003D444020;
                8'h6B: g = 40'h004428107F;
                8'h6C: g = 40'h00407F4100;
                8'h6D: g = 40'h780418047C;
                8'h6E: g = 40'h780404087C;
                8'h6F: g = 40'h3844444438;
                8'h70: g = 40'h081414147C;
                8'h71: g = 40'h7C18141408;
                8'h72: g = 40'h080404087C;
                8'h73: g = 40'h2054545448;
                8'h74: g = 40'h2040443F04;
                8'h75: g = 40'h7C2040403C;
                8'h76: g = 40'h1C2040201C;
                8'h77: g = 40'h3C4030403C;
                8'h78: g = 40'h4428102844;
                8'h79: g = 40'h3C5050500C;
                8'h7A: g = 40'h444C546444;
                // space and every code outside the font render blank
                default: g = '0;
            endcase
            return g;
        end
    endfunction

endpackage

// File: design/sftr_glyph_scan.sv
module sftr_glyph_scan (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  sftr_pkg::glyph_t              glyph,
    input  logic [sftr_pkg::COORD_W-1:0]  col,
    input  logic [sftr_pkg::COORD_W-1:0]  row,
    input  logic [sftr_pkg::SCALE_W-1:0]  scale,
    input  logic                          advance,
    output logic                          busy,
    output sftr_pkg::dot_t                dot
);

    sftr_pkg::glyph_t                    glyph_reg;
    logic [sftr_pkg::ROW_IDX_W-1:0]      row_idx_reg;
    logic [sftr_pkg::COORD_W-1:0]        x_reg;
    logic [sftr_pkg::COORD_W-1:0]        y_reg;
    logic [sftr_pkg::COORD_W-1:0]        base_row_reg;
    logic [sftr_pkg::SCALE_W-1:0]        scale_reg;
    logic                                busy_reg;
    logic                                rest_empty;
    logic [sftr_pkg::COORD_W-1:0]        scale_ext;

    assign rest_empty = ~|glyph_reg[sftr_pkg::GLYPH_W-1:1];
    assign scale_ext  = {{(sftr_pkg::COORD_W - sftr_pkg::SCALE_W){1'b0}}, scale_reg};

    // scan stops right after the last lit dot, so trailing blank bits cost nothing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= |glyph;
        end
        else if (advance && busy_reg)
        begin
            busy_reg <= !rest_empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            glyph_reg    <= glyph;
            row_idx_reg  <= '0;
            x_reg        <= col;
            y_reg        <= row;
            base_row_reg <= row;
            scale_reg    <= scale;
        end
        else if (advance && busy_reg)
        begin
            glyph_reg   <= glyph_reg >> 1;
            row_idx_reg <= row_idx_reg + 1'b1;
            if (row_idx_reg == sftr_pkg::LAST_ROW)
            begin
                x_reg <= x_reg + scale_ext;
                y_reg <= base_row_reg;
            end
            else
            begin
                y_reg <= y_reg + scale_ext;
            end
        end
    end

    assign busy      = busy_reg;
    assign dot.valid = busy_reg && glyph_reg[0];
    assign dot.last  = rest_empty;
    assign dot.x     = x_reg;
    assign dot.y     = y_reg;
    assign dot.side  = scale_reg;

endmodule

// File: design/scaled_font_text_renderer.sv
// Scaled 5x7 text renderer.
// Input stream (s_*): one character per transaction with the string origin,
// the scale and a first-of-string flag in tuser. The block keeps a text cursor;
// a newline moves it to the origin column and 8*scale rows down, emitting
// nothing. Other characters are scanned from the font ROM column by column,
// dot row 0..7, and each lit dot leaves as one square on the output stream
// (m_*) with tlast on the final square of the character.
// Flow: a newline, space or unknown code does not hold up the input. A glyph is
// loaded into the glyph shift register, which then moves one bit a cycle up to and
// including its last lit dot (at most 39 bits with this font), except that it
// stalls on a lit dot while the output register cannot take it. The first square
// passes through the glyph shift register and then the output register, after any
// blank bits ahead of it. The next character is taken as soon as the scan finishes,
// while the last square may still wait in the output register.
// Reset clears the cursor to (0,0) and empties the output register.
// When the receiver holds m_tready low the scan stops on the pending lit dot
// and resumes when the output register frees up; nothing is dropped.
module scaled_font_text_renderer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // char_code[7:0], origin_x[23:8], origin_y[39:24],
                                   // scale[43:40], zero[47:44]
    input  logic [0:0]  s_tuser,   // first_char[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // dot_x[15:0], dot_y[31:16], side[35:32], zero[39:36]
    output logic        m_tlast    // last_dot
);

    logic [sftr_pkg::CODE_W-1:0]    char_code;
    logic [sftr_pkg::COORD_W-1:0]   origin_x;
    logic [sftr_pkg::COORD_W-1:0]   origin_y;
    logic [sftr_pkg::SCALE_W-1:0]   scale;
    logic                           first_char;

    logic [sftr_pkg::COORD_W-1:0]   cursor_col_reg;
    logic [sftr_pkg::COORD_W-1:0]   cursor_row_reg;
    logic [sftr_pkg::COORD_W-1:0]   eff_col;
    logic [sftr_pkg::COORD_W-1:0]   eff_row;
    logic [sftr_pkg::ADV_W-1:0]     adv_x;
    logic [sftr_pkg::ADV_W-1:0]     adv_y;

    logic                           in_accept;
    logic                           is_newline;
    logic                           scan_start;
    logic                           scan_busy;
    logic                           scan_advance;
    logic                           slot_free;
    logic                           out_load;
    sftr_pkg::dot_t                 dot;

    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [sftr_pkg::COORD_W-1:0]   out_x_reg;
    logic [sftr_pkg::COORD_W-1:0]   out_y_reg;
    logic [sftr_pkg::SCALE_W-1:0]   out_side_reg;
    logic                           out_last_reg;

    assign char_code  = s_tdata[7:0];
    assign origin_x   = s_tdata[23:8];
    assign origin_y   = s_tdata[39:24];
    assign scale      = s_tdata[43:40];
    assign first_char = s_tuser[0];

    assign s_tready   = !scan_busy;
    assign in_accept  = s_tvalid && s_tready;
    assign is_newline = (char_code == sftr_pkg::NEWLINE_CODE);
    assign scan_start = in_accept && !is_newline;

    assign eff_col = first_char ? origin_x : cursor_col_reg;
    assign eff_row = first_char ? origin_y : cursor_row_reg;
    // 6*scale and 8*scale by shifts
    assign adv_x = {1'b0, scale, 2'b00} + {2'b00, scale, 1'b0};
    assign adv_y = {scale, 3'b000};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_col_reg <= '0;
            cursor_row_reg <= '0;
        end
        else if (in_accept)
        begin
            if (is_newline)
            begin
                cursor_col_reg <= origin_x;
                cursor_row_reg <= eff_row
                    + {{(sftr_pkg::COORD_W - sftr_pkg::ADV_W){1'b0}}, adv_y};
            end
            else
            begin
                cursor_col_reg <= eff_col
                    + {{(sftr_pkg::COORD_W - sftr_pkg::ADV_W){1'b0}}, adv_x};
                cursor_row_reg <= eff_row;
            end
        end
    end

    sftr_glyph_scan u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (scan_start),
        .glyph   (sftr_pkg::font_glyph(char_code)),
        .col     (eff_col),
        .row     (eff_row),
        .scale   (scale),
        .advance (scan_advance),
        .busy    (scan_busy),
        .dot     (dot)
    );

    // blank bits pass freely; a lit dot waits for room in the output register
    assign slot_free    = !out_valid_reg || m_tready;
    assign scan_advance = scan_busy && (!dot.valid || slot_free);
    assign out_load     = dot.valid && slot_free;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_x_reg    <= dot.x;
            out_y_reg    <= dot.y;
            out_side_reg <= dot.side;
            out_last_reg <= dot.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_side_reg, out_y_reg, out_x_reg};
    assign m_tlast  = out_last_reg;

    // a transaction offered by the scanner always lands in the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid_reg)
        else $error("lit dot was not captured in the output register");

    // the scan ends right after its last lit dot leaves
    assert property (@(posedge clk) disable iff (!rst_n)
        dot.valid && dot.last && scan_advance |=> !scan_busy)
        else $error("scan kept running after the final square");

    // the scan only finishes on a step
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(scan_busy) |-> $past(scan_advance))
        else $error("scan stopped without advancing");

    // a stalled scan is never aborted: it stays busy until it advances
    assert property (@(posedge clk) disable iff (!rst_n)
        scan_busy && !scan_advance |=> scan_busy)
        else $error("scan aborted while stalled");

endmodule

// File: tb/sv/tb_top.sv
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT  = 5000;
    localparam int DRAIN_WAIT  = 60;
    localparam int RANDOM_CHARS = 200;

    // 5x7 font, codes 0x20..0x7A, five column bytes each, dot row r at bit r
    localparam logic [7:0] FONT_COLS [91][5] = '{
        '{'h00,'h00,'h00,'h00,'h00}, '{'h00,'h00,'h5F,'h00,'h00}, '{'h00,'h07,'h00,'h07,'h00},
        '{'h14,'h7F,'h14,'h7F,'h14}, '{'h24,'h2A,'h7F,'h2A,'h12}, '{'h23,'h13,'h08,'h64,'h62},
        '{'h36,'h49,'h55,'h22,'h50}, '{'h00,'h05,'h03,'h00,'h00}, '{'h00,'h1C,'h22,'h41,'h00},
        '{'h00,'h41,'h22,'h1C,'h00}, '{'h14,'h08,'h3E,'h08,'h14}, '{'h08,'h08,'h3E,'h08,'h08},
        '{'h00,'h50,'h30,'h00,'h00}, '{'h08,'h08,'h08,'h08,'h08}, '{'h00,'h60,'h60,'h00,'h00},
        '{'h20,'h10,'h08,'h04,'h02}, '{'h3E,'h51,'h49,'h45,'h3E}, '{'h00,'h42,'h7F,'h40,'h00},
        '{'h42,'h61,'h51,'h49,'h46}, '{'h21,'h41,'h45,'h4B,'h31}, '{'h18,'h14,'h12,'h7F,'h10},
        '{'h27,'h45,'h45,'h45,'h39}, '{'h3C,'h4A,'h49,'h49,'h30}, '{'h01,'h71,'h09,'h05,'h03},
        '{'h36,'h49,'h49,'h49,'h36}, '{'h06,'h49,'h49,'h29,'h1E}, '{'h00,'h36,'h36,'h00,'h00},
        '{'h00,'h56,'h36,'h00,'h00}, '{'h08,'h14,'h22,'h41,'h00}, '{'h14,'h14,'h14,'h14,'h14},
        '{'h00,'h41,'h22,'h14,'h08}, '{'h02,'h01,'h51,'h09,'h06}, '{'h32,'h49,'h79,'h41,'h3E},
        '{'h7E,'h11,'h11,'h11,'h7E}, '{'h7F,'h49,'h49,'h49,'h36}, '{'h3E,'h41,'h41,'h41,'h22},
        '{'h7F,'h41,'h41,'h22,'h1C}, '{'h7F,'h49,'h49,'h49,'h41}, '{'h7F,'h09,'h09,'h09,'h01},
        '{'h3E,'h41,'h49,'h49,'h7A}, '{'h7F,'h08,'h08,'h08,'h7F}, '{'h00,'h41,'h7F,'h41,'h00},
        '{'h20,'h40,'h41,'h3F,'h01}, '{'h7F,'h08,'h14,'h22,'h41}, '{'h7F,'h40,'h40,'h40,'h40},
        '{'h7F,'h02,'h0C,'h02,'h7F}, '{'h7F,'h04,'h08,'h10,'h7F}, '{'h3E,'h41,'h41,'h41,'h3E},
        '{'h7F,'h09,'h09,'h09,'h06}, '{'h3E,'h41,'h51,'h21,'h5E}, '{'h7F,'h09,'h19,'h29,'h46},
        '{'h46,'h49,'h49,'h49,'h31}, '{'h01,'h01,'h7F,'h01,'h01}, '{'h3F,'h40,'h40,'h40,'h3F},
        '{'h1F,'h20,'h40,'h20,'h1F}, '{'h3F,'h40,'h38,'h40,'h3F}, '{'h63,'h14,'h08,'h14,'h63},
        '{'h07,'h08,'h70,'h08,'h07}, '{'h61,'h51,'h49,'h45,'h43}, '{'h00,'h7F,'h41,'h41,'h00},
        '{'h02,'h04,'h08,'h10,'h20}, '{'h00,'h41,'h41,'h7F,'h00}, '{'h04,'h02,'h01,'h02,'h04},
        '{'h40,'h40,'h40,'h40,'h40}, '{'h00,'h01,'h02,'h04,'h00}, '{'h20,'h54,'h54,'h54,'h78},
        '{'h7F,'h48,'h44,'h44,'h38}, '{'h38,'h44,'h44,'h44,'h20}, '{'h38,'h44,'h44,'h48,'h7F},
        '{'h38,'h54,'h54,'h54,'h18}, '{'h08,'h7E,'h09,'h01,'h02}, '{'h0C,'h52,'h52,'h52,'h3E},
        '{'h7F,'h08,'h04,'h04,'h78}, '{'h00,'h44,'h7D,'h40,'h00}, '{'h20,'h40,'h44,'h3D,'h00},
        '{'h7F,'h10,'h28,'h44,'h00}, '{'h00,'h41,'h7F,'h40,'h00}, '{'h7C,'h04,'h18,'h04,'h78},
        '{'h7C,'h08,'h04,'h04,'h78}, '{'h38,'h44,'h44,'h44,'h38}, '{'h7C,'h14,'h14,'h14,'h08},
        '{'h08,'h14,'h14,'h18,'h7C}, '{'h7C,'h08,'h04,'h04,'h08}, '{'h48,'h54,'h54,'h54,'h20},
        '{'h04,'h3F,'h44,'h40,'h20}, '{'h3C,'h40,'h40,'h20,'h7C}, '{'h1C,'h20,'h40,'h20,'h1C},
        '{'h3C,'h40,'h30,'h40,'h3C}, '{'h44,'h28,'h10,'h28,'h44}, '{'h0C,'h50,'h50,'h50,'h3C},
        '{'h44,'h64,'h54,'h4C,'h44}
    };

    typedef struct {
        bit [15:0] x;
        bit [15:0] y;
        bit [3:0]  side;
        bit        last;
    } square_t;

    class text_cursor_model;
        bit [15:0] cursor_col;
        bit [15:0] cursor_row;
        square_t   squares_due[$];
        int        errors;
        int        chars_seen;
        int        newlines_seen;
        int        blanks_seen;
        int        squares_checked;

        function new();
            cursor_col = '0;
            cursor_row = '0;
        endfunction

        // expand one accepted character into the squares it should produce
        function void take_char(bit [7:0] code, bit [15:0] ox, bit [15:0] oy, bit [3:0] sc,
                                bit first);
            square_t   held;
            bit        have_held;
            bit [7:0]  column_bits;
            bit [7:0]  glyph;
            have_held = 1'b0;
            chars_seen++;
            if (first)
            begin
                cursor_col = ox;
                cursor_row = oy;
            end
            if (code == sftr_pkg::NEWLINE_CODE)
            begin
                cursor_col = ox;
                cursor_row = cursor_row + 16'(8 * sc);
                newlines_seen++;
                return;
            end
            glyph = code;
            if (glyph < sftr_pkg::GLYPH_FIRST || glyph > sftr_pkg::GLYPH_LAST)
                glyph = sftr_pkg::GLYPH_FIRST;
            for (int c = 0; c < 5; c++)
            begin
                column_bits = FONT_COLS[glyph - sftr_pkg::GLYPH_FIRST][c];
                for (int b = 0; b < 8; b++)
                begin
                    if (column_bits[b])
                    begin
                        // push lazily so the final square can carry the last flag
                        if (have_held)
                            squares_due.push_back(held);
                        held.x    = cursor_col + 16'(c * sc);
                        held.y    = cursor_row + 16'(b * sc);
                        held.side = sc;
                        held.last = 1'b0;
                        have_held = 1'b1;
                    end
                end
            end
            if (have_held)
            begin
                held.last = 1'b1;
                squares_due.push_back(held);
            end
            else
                blanks_seen++;
            cursor_col = cursor_col + 16'(6 * sc);
        endfunction

        function void check_square(logic [39:0] data, logic last);
            square_t want;
            if (squares_due.size() == 0)
            begin
                $error("square with nothing expected: dot_x=%0h dot_y=%0h side=%0d",
                       data[15:0], data[31:16], data[35:32]);
                errors++;
                return;
            end
            want = squares_due.pop_front();
            squares_checked++;
            if (data[15:0] !== want.x)
            begin
                $error("dot_x: expected %0h, got %0h", want.x, data[15:0]);
                errors++;
            end
            if (data[31:16] !== want.y)
            begin
                $error("dot_y: expected %0h, got %0h", want.y, data[31:16]);
                errors++;
            end
            if (data[35:32] !== want.side)
            begin
                $error("side: expected %0d, got %0d", want.side, data[35:32]);
                errors++;
            end
            if (last !== want.last)
            begin
                $error("last_dot: expected %0b, got %0b", want.last, last);
                errors++;
            end
        endfunction

        function int outstanding();
            return squares_due.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;   // char_code, origin_x, origin_y, scale, zero pad
    logic [0:0]  s_tuser = '0;   // first_char
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;        // dot_x, dot_y, side, zero pad
    logic        m_tlast;

    text_cursor_model model;
    int burst_left = 0;
    int idle_cycles = 0;
    int stall_phase = 0;
    int stall_mode = 0;

    scaled_font_text_renderer u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    // receiver backpressure: a new pattern is drawn each time stall_phase counts down to zero
    always @(posedge clk)
    begin
        if (stall_phase == 0)
        begin
            stall_mode  <= $urandom_range(0, 3);
            stall_phase <= 200;
        end
        else
            stall_phase <= stall_phase - 1;
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            2:       m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= (stall_phase % 3 != 0);
        endcase
    end

    // transaction monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                model.take_char(s_tdata[7:0], s_tdata[23:8], s_tdata[39:24], s_tdata[43:40],
                                s_tuser[0]);
            if (m_tvalid && m_tready)
                model.check_square(m_tdata, m_tlast);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic send_char(input bit [7:0] code, input bit [15:0] ox, input bit [15:0] oy,
                             input bit [3:0] sc, input bit first);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, sc, oy, ox, code};
        s_tuser  <= first;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    function automatic bit [15:0] pick_coord();
        case ($urandom_range(0, 3))
            0:       return 16'h7FFF - 16'($urandom_range(0, 40));
            1:       return 16'hFFFF - 16'($urandom_range(0, 40));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic bit [3:0] pick_scale();
        if ($urandom_range(0, 9) == 0)
            return 4'($urandom_range(0, 15));
        return 4'($urandom_range(1, 8));
    endfunction

    initial
    begin
        int        str_len;
        int        roll;
        int        random_sent;
        bit        broken;
        bit [7:0]  code;
        bit [15:0] ox;
        bit [15:0] oy;
        bit [3:0]  sc;

        model = new();
        random_sent = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: glyph extremes, blanks, out-of-range codes, newlines, scale corners
        send_char(8'h41, 16'h0000, 16'h0000, 4'd1, 1'b1);
        send_char(8'h23, 16'h0000, 16'h0000, 4'd1, 1'b0);   // one of the densest glyphs, 20 dots
        send_char(sftr_pkg::GLYPH_FIRST, 16'h0000, 16'h0000, 4'd1, 1'b0);
        send_char(8'h00, 16'h0000, 16'h0000, 4'd1, 1'b0);
        send_char(8'hFF, 16'h0000, 16'h0000, 4'd1, 1'b0);
        send_char(8'h7B, 16'h0000, 16'h0000, 4'd1, 1'b0);
        send_char(8'h1F, 16'h0000, 16'h0000, 4'd1, 1'b0);
        send_char(sftr_pkg::GLYPH_LAST, 16'h0000, 16'h0000, 4'd1, 1'b0);
        send_char(sftr_pkg::NEWLINE_CODE, 16'h0000, 16'h0000, 4'd1, 1'b0);
        send_char(sftr_pkg::NEWLINE_CODE, 16'h7FFF, 16'h7FFF, 4'd8, 1'b1);
        send_char(8'h23, 16'h7FFF, 16'h7FFF, 4'd8, 1'b0);
        send_char(8'h57, 16'h8000, 16'h8000, 4'd15, 1'b1);
        send_char(8'h4D, 16'h8000, 16'h8000, 4'd15, 1'b0);
        send_char(8'h21, 16'h7FF0, 16'h0010, 4'd0, 1'b1);   // zero scale stays put
        send_char(8'h40, 16'h7FF0, 16'h0010, 4'd0, 1'b0);
        send_char(sftr_pkg::NEWLINE_CODE, 16'h7FF0, 16'h0010, 4'd0, 1'b0);
        send_char(8'h67, 16'hFFFF, 16'hFFFF, 4'd9, 1'b1);
        send_char(8'h7E, 16'hFFFF, 16'hFFFF, 4'd9, 1'b0);
        send_char(8'h80, 16'hFFFF, 16'hFFFF, 4'd9, 1'b0);
        send_char(8'h42, 16'hFFFF, 16'hFFFF, 4'd9, 1'b0);
        send_char(8'h30, 16'h0000, 16'h0000, 4'd1, 1'b1);

        // random strings; a few are broken (origin_x/scale drift, stray first flags)
        while (random_sent < RANDOM_CHARS)
        begin
            str_len = $urandom_range(1, 12);
            ox = pick_coord();
            oy = pick_coord();
            sc = pick_scale();
            broken = ($urandom_range(0, 9) == 0);
            for (int i = 0; i < str_len; i++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 70)
                    code = 8'($urandom_range(sftr_pkg::GLYPH_FIRST + 1, sftr_pkg::GLYPH_LAST));
                else if (roll < 78)
                    code = sftr_pkg::GLYPH_FIRST;
                else if (roll < 88)
                    code = sftr_pkg::NEWLINE_CODE;
                else
                    code = 8'($urandom_range(0, 255));
                if (broken)
                begin
                    ox = pick_coord();
                    sc = pick_scale();
                end
                send_char(code, ox, oy, sc, (i == 0) || (broken && $urandom_range(0, 3) == 0));
                random_sent++;
            end
        end
        s_tvalid <= 1'b0;
        // let the monitor log the final character before looking at the queue
        @(posedge clk);

        while (model.outstanding() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Rendered %0d characters (%0d newlines, %0d blank glyphs) over scales 0..15",
                 model.chars_seen, model.newlines_seen, model.blanks_seen);
        $display("Checked %0d squares with random source gaps and sink stalls",
                 model.squares_checked);
        if (model.errors == 0 && model.outstanding() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
